FILE: hw/rtl/bfp_pkg.sv
// Shared types, constants and helpers for the binary field packer.
// No dependencies; used by every module of the packer.
`default_nettype none

package bfp_pkg;

  localparam int OFFSET_WIDTH = 16;
  localparam int CMP_W        = OFFSET_WIDTH + 17;

  localparam logic [OFFSET_WIDTH-1:0] POS_CAP = {OFFSET_WIDTH{1'b1}};

  localparam int BUF_SIZE_W = 16;
  localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 16'hFFFF;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_IDX_BUFFER_SIZE = 1'b0;

  // command queue between front and back end
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // format codes
  localparam logic [3:0] OP_PAD    = 4'd0;
  localparam logic [3:0] OP_BYTE   = 4'd1;
  localparam logic [3:0] OP_HALF   = 4'd2;
  localparam logic [3:0] OP_WORD   = 4'd3;
  localparam logic [3:0] OP_DWORD  = 4'd4;
  localparam logic [3:0] OP_LITTLE = 4'd5;
  localparam logic [3:0] OP_BIG    = 4'd6;
  localparam logic [3:0] OP_FINISH = 4'd7;

  typedef enum logic [1:0] {
    KIND_PAD,
    KIND_FIELD,
    KIND_FINISH
  } kind_t;

  // one request for the back end
  typedef struct packed {
    kind_t                   kind;
    logic [2:0]              count_m1;  // field bytes minus one
    logic [63:0]             value;
    logic [OFFSET_WIDTH-1:0] start;     // position of the first byte
    logic                    big;
    logic                    err;
  } cmd_t;

  // offsets and lengths leave the block on 16 bits, clamped
  function automatic logic [15:0] clamp16(input logic [OFFSET_WIDTH-1:0] v);
    logic [OFFSET_WIDTH+15:0] ext;
    ext = (OFFSET_WIDTH + 16)'(v);
    return (ext[OFFSET_WIDTH+15:16] != '0) ? 16'hFFFF : ext[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bfp_front.sv
// Front end: takes format items, keeps position / byte order / error state,
// and queues pad, field and finish requests. Depends on bfp_pkg.
`default_nettype none

module bfp_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [3:0]            op,
  input  wire logic [63:0]           field_value,
  output logic                       full,
  input  wire logic                  q_full,
  output logic                       q_wr,
  output bfp_pkg::cmd_t              q_data
);

  logic [bfp_pkg::OFFSET_WIDTH-1:0] pos;
  logic [bfp_pkg::OFFSET_WIDTH-1:0] pos_next;
  logic                             big;
  logic                             big_next;
  logic                             err;
  logic                             err_next;

  logic                             accept;
  logic [2:0]                       field_m1;
  logic [3:0]                       field_n;
  logic [bfp_pkg::OFFSET_WIDTH-1:0] room;

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign field_n = 4'({1'b0, field_m1}) + 4'd1;
  assign room    = bfp_pkg::POS_CAP - pos;

  always_comb begin
    case (op)
      bfp_pkg::OP_HALF:  field_m1 = 3'd1;
      bfp_pkg::OP_WORD:  field_m1 = 3'd3;
      bfp_pkg::OP_DWORD: field_m1 = 3'd7;
      default:           field_m1 = 3'd0;
    endcase
  end

  always_comb begin
    pos_next        = pos;
    big_next        = big;
    err_next        = err;
    q_wr            = 1'b0;
    q_data.kind     = bfp_pkg::KIND_PAD;
    q_data.count_m1 = 3'd0;
    q_data.value    = field_value;
    q_data.start    = pos;
    q_data.big      = big;
    q_data.err      = err;
    if (accept) begin
      case (op)
        bfp_pkg::OP_PAD: begin
          q_wr     = 1'b1;
          pos_next = (pos != bfp_pkg::POS_CAP) ? pos + 1'b1 : bfp_pkg::POS_CAP;
          big_next = 1'b0;
        end
        bfp_pkg::OP_BYTE, bfp_pkg::OP_HALF, bfp_pkg::OP_WORD, bfp_pkg::OP_DWORD: begin
          q_wr            = 1'b1;
          q_data.kind     = bfp_pkg::KIND_FIELD;
          q_data.count_m1 = field_m1;
          pos_next = (bfp_pkg::OFFSET_WIDTH'(field_n) <= room)
                   ? pos + bfp_pkg::OFFSET_WIDTH'(field_n) : bfp_pkg::POS_CAP;
          big_next = 1'b0;
        end
        bfp_pkg::OP_LITTLE: begin
          big_next = 1'b0;
        end
        bfp_pkg::OP_BIG: begin
          big_next = 1'b1;
        end
        bfp_pkg::OP_FINISH: begin
          q_wr        = 1'b1;
          q_data.kind = bfp_pkg::KIND_FINISH;
          pos_next    = '0;
          big_next    = 1'b0;
          err_next    = 1'b0;
        end
        default: begin
          err_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      big <= 1'b0;
      err <= 1'b0;
    end else begin
      pos <= pos_next;
      big <= big_next;
      err <= err_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bfp_cmd_fifo.sv
// Short request queue between the front and back end of the packer.
// Depends on bfp_pkg for the request type and depth.
`default_nettype none

module bfp_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire bfp_pkg::cmd_t wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output bfp_pkg::cmd_t      rd_data,
  output logic               not_empty
);

  bfp_pkg::cmd_t                  entries [bfp_pkg::CMDQ_DEPTH];
  logic [bfp_pkg::CMDQ_PTR_W-1:0] head;
  logic [bfp_pkg::CMDQ_PTR_W-1:0] tail;
  logic [bfp_pkg::CMDQ_CNT_W-1:0] count;

  assign full      = (count == bfp_pkg::CMDQ_CNT_W'(bfp_pkg::CMDQ_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = entries[head];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[tail] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        tail <= tail + 1'b1;
      end
      if (rd_en) begin
        head <= head + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bfp_back.sv
// Back end: expands queued requests into one byte result per cycle as
// results are popped, held in an output register. Depends on bfp_pkg.
`default_nettype none

module bfp_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [15:0]           buffer_size,
  input  wire bfp_pkg::cmd_t         head,
  input  wire logic                  head_valid,
  output logic                       head_pop,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [7:0]                 out_byte,
  output logic [15:0]                byte_offset,
  output logic                       write_enable,
  output logic                       last,
  output logic                       record_done,
  output logic [15:0]                record_length,
  output logic                       record_error
);

  logic                                 out_valid;
  logic [2:0]                           byte_idx;
  logic                                 advance;
  logic                                 item_end;
  logic [bfp_pkg::OFFSET_WIDTH:0]       raw;
  logic [bfp_pkg::OFFSET_WIDTH-1:0]     pos_sat;
  logic [2:0]                           sel;
  logic [7:0]                           sel_byte;
  logic                                 we;

  assign empty    = !out_valid;
  assign advance  = head_valid && (!out_valid || pop);
  assign item_end = (byte_idx == head.count_m1);
  assign head_pop = advance && item_end;

  assign raw     = {1'b0, head.start} + (bfp_pkg::OFFSET_WIDTH + 1)'(byte_idx);
  assign pos_sat = raw[bfp_pkg::OFFSET_WIDTH] ? bfp_pkg::POS_CAP
                                              : raw[bfp_pkg::OFFSET_WIDTH-1:0];
  assign sel      = head.big ? (head.count_m1 - byte_idx) : byte_idx;
  assign sel_byte = head.value[8*sel +: 8];
  // the cap position itself is never written
  assign we = !head.err
           && (bfp_pkg::CMP_W'(raw) < bfp_pkg::CMP_W'(bfp_pkg::POS_CAP))
           && (bfp_pkg::CMP_W'(raw) < bfp_pkg::CMP_W'(buffer_size));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        byte_idx  <= item_end ? 3'd0 : byte_idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      case (head.kind)
        bfp_pkg::KIND_FIELD: begin
          out_byte      <= sel_byte;
          byte_offset   <= bfp_pkg::clamp16(pos_sat);
          write_enable  <= we;
          last          <= item_end;
          record_done   <= 1'b0;
          record_length <= 16'd0;
          record_error  <= 1'b0;
        end
        bfp_pkg::KIND_FINISH: begin
          out_byte      <= 8'd0;
          byte_offset   <= bfp_pkg::clamp16(head.start);
          write_enable  <= 1'b0;
          last          <= 1'b1;
          record_done   <= 1'b1;
          record_length <= bfp_pkg::clamp16(head.start);
          record_error  <= head.err;
        end
        default: begin
          out_byte      <= 8'd0;
          byte_offset   <= bfp_pkg::clamp16(head.start);
          write_enable  <= 1'b0;
          last          <= 1'b1;
          record_done   <= 1'b0;
          record_length <= 16'd0;
          record_error  <= 1'b0;
        end
      endcase
    end
  end

  // a partly emitted field keeps its request at the queue head
  a_idx_needs_head: assert property (@(posedge clk) disable iff (rst)
    (byte_idx != 3'd0) |-> head_valid)
    else $error("byte index advanced without a queued request");

  a_idx_steps: assert property (@(posedge clk) disable iff (rst)
    (advance && !item_end) |=> (byte_idx == $past(byte_idx) + 3'd1))
    else $error("byte index did not step within a field");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_done) |-> (last && !write_enable))
    else $error("finish result not marked last or written");

  a_write_in_buffer: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_enable) |-> (byte_offset < buffer_size))
    else $error("byte written beyond buffer size");

endmodule

`default_nettype wire

FILE: hw/rtl/binary_field_packer_core.sv
// Top level of the binary field packer: configuration register, front end,
// request queue and back end. Depends on bfp_pkg, bfp_front, bfp_cmd_fifo, bfp_back.
//
//   channel   handshake             payload
//   input     push / full           op, field_value
//   result    empty / pop           out_byte, byte_offset, write_enable, last,
//                                   record_done, record_length, record_error
//   config    psel/penable/pready   paddr, pwrite, pwdata, prdata (buffer_size)
//
// The front end takes one item per cycle while the 4-entry request queue has room.
// The back end emits one result per cycle as they are popped: n for a field of n bytes,
// one for pad and finish, none for markers and invalid codes (they end in the front end).
// A result waits in the output register; the back end moves on as it is taken.
// Reset is synchronous and active high; buffer_size resets to 65535.
`default_nettype none

module binary_field_packer_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input queue
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [3:0]                  op,
  input  wire logic [63:0]                 field_value,
  // result queue
  output logic                             empty,
  input  wire logic                        pop,
  output logic [7:0]                       out_byte,
  output logic [15:0]                      byte_offset,
  output logic                             write_enable,
  output logic                             last,
  output logic                             record_done,
  output logic [15:0]                      record_length,
  output logic                             record_error,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bfp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [bfp_pkg::PDATA_W-1:0] pwdata,
  output logic [bfp_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  logic [bfp_pkg::BUF_SIZE_W-1:0] buffer_size;
  logic                           reg_sel;

  bfp_pkg::cmd_t q_wr_data;
  bfp_pkg::cmd_t q_rd_data;
  logic          q_wr;
  logic          q_full;
  logic          q_rd;
  logic          q_not_empty;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[bfp_pkg::PADDR_W-1] == bfp_pkg::REG_IDX_BUFFER_SIZE);
  assign prdata  = reg_sel ? bfp_pkg::PDATA_W'(buffer_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= bfp_pkg::BUF_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      buffer_size <= pwdata[bfp_pkg::BUF_SIZE_W-1:0];
    end
  end

  bfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .op          (op),
    .field_value (field_value),
    .full        (full),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_data      (q_wr_data)
  );

  bfp_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (q_wr),
    .wr_data   (q_wr_data),
    .full      (q_full),
    .rd_en     (q_rd),
    .rd_data   (q_rd_data),
    .not_empty (q_not_empty)
  );

  bfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .buffer_size   (buffer_size),
    .head          (q_rd_data),
    .head_valid    (q_not_empty),
    .head_pop      (q_rd),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .byte_offset   (byte_offset),
    .write_enable  (write_enable),
    .last          (last),
    .record_done   (record_done),
    .record_length (record_length),
    .record_error  (record_error)
  );

endmodule

`default_nettype wire
